@@ rtl/keyed_lru_slot_cache_unit_assert.svh @@
// assertion macros for the slot cache checker
`ifndef KEYED_LRU_SLOT_CACHE_UNIT_ASSERT_SVH
`define KEYED_LRU_SLOT_CACHE_UNIT_ASSERT_SVH

// same-cycle implication
`define KLSC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("slot cache check failed");

// next-cycle implication
`define KLSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("slot cache check failed");

`endif

@@ rtl/klsc_pkg.sv @@
// package with payload types and constants of the slot cache
package klsc_pkg;

  localparam int unsigned KEY_W      = 64;
  localparam int unsigned HANDLE_W   = 32;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned KB_W       = 4;
  localparam int unsigned DEF_SLOTS  = 8;
  localparam int unsigned DEF_KEY_BITS    = 64;
  localparam int unsigned DEF_HANDLE_BITS = 32;

  localparam logic [KB_W-1:0]    KEY_BYTES_RESET = KB_W'(8);
  localparam logic [STAMP_W-1:0] STAMP_MAX       = '1;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic                op;
    logic [KEY_W-1:0]    search_key;
    logic [HANDLE_W-1:0] plan_handle;
    logic [HANDLE_W-1:0] spline_handle;
    logic [HANDLE_W-1:0] accel_handle;
  } klsc_in_t;

  typedef struct packed {
    logic                hit;
    logic [IDX_W-1:0]    slot_index;
    logic [HANDLE_W-1:0] plan_out_handle;
    logic [HANDLE_W-1:0] spline_out_handle;
    logic [HANDLE_W-1:0] accel_out_handle;
  } klsc_out_t;

endpackage

@@ rtl/keyed_lru_slot_cache_unit.sv @@
// top level of the keyed lru slot cache with its scanning sequencer
//
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  in       | in_valid_i, in_ready_o, in_i     | item in
//  out      | out_valid_o, out_ready_i, out_o  | item out
//  cfg      | cfg_valid_i, cfg_ready_o, cfg_data_i | key_bytes write
//
//  slots are scanned one at a time over a single key/stamp compare path:
//  each slot visited takes a memory read step and a compare step, and the
//  item ends with a write step and an output step; at most SLOTS slots are
//  visited. a lookup miss skips the write step.
//  reset clears valid bits, use clock and key_bytes (8); no clearing pass.
//  a result waiting on out_ready_i holds only the output step; the next
//  item is taken as soon as the result is registered.
module keyed_lru_slot_cache_unit #(
  parameter int unsigned SLOTS       = klsc_pkg::DEF_SLOTS,
  parameter int unsigned KEY_BITS    = klsc_pkg::DEF_KEY_BITS,
  parameter int unsigned HANDLE_BITS = klsc_pkg::DEF_HANDLE_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  klsc_pkg::klsc_in_t       in_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output klsc_pkg::klsc_out_t      out_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [klsc_pkg::KB_W-1:0] cfg_data_i
);
  import klsc_pkg::*;

  localparam int unsigned IW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned MAX_BYTES = KEY_BITS / 8;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_CHECK  = 5'b00100,
    S_WRITE  = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [SLOTS-1:0]     valid_q, valid_d;
  logic [STAMP_W-1:0]   clock_q, clock_d;
  logic [KB_W-1:0]      key_bytes_q, key_bytes_d;
  logic                 out_valid_q, out_valid_d;
  logic [IW-1:0]        scan_q, scan_d;
  logic [IW-1:0]        best_q, best_d;
  logic [IW-1:0]        target_q, target_d;
  logic [STAMP_W-1:0]   best_stamp_q, best_stamp_d;
  klsc_in_t             req_q, req_d;
  klsc_out_t            res_q, res_d;
  klsc_out_t            out_q, out_d;

  logic [KEY_BITS-1:0]    key_mem   [SLOTS];
  logic [STAMP_W-1:0]     stamp_mem [SLOTS];
  logic [HANDLE_BITS-1:0] plan_mem  [SLOTS];
  logic [HANDLE_BITS-1:0] spline_mem[SLOTS];
  logic [HANDLE_BITS-1:0] accel_mem [SLOTS];

  logic [KEY_BITS-1:0]    rd_key_q;
  logic [STAMP_W-1:0]     rd_stamp_q;
  logic [HANDLE_BITS-1:0] rd_plan_q, rd_spline_q, rd_accel_q;

  logic [KB_W-1:0]      kb_eff;
  logic [KEY_W-1:0]     key_mask;
  logic [KEY_W-1:0]     req_key_m;
  logic                 key_eq;
  logic                 stamp_lt;
  logic                 last_slot;
  logic [STAMP_W-1:0]   clock_inc;
  logic                 stamp_we;
  logic                 entry_we;

  // effective key width, clamped to one byte and to the key storage
  always_comb begin
    if (key_bytes_q == '0) begin
      kb_eff = KB_W'(1);
    end else if (key_bytes_q > KB_W'(MAX_BYTES)) begin
      kb_eff = KB_W'(MAX_BYTES);
    end else begin
      kb_eff = key_bytes_q;
    end
    for (int j = 0; j < KEY_W; j++) begin
      key_mask[j] = KB_W'(j / 8) < kb_eff;
    end
  end

  assign req_key_m = req_q.search_key & key_mask;
  assign key_eq    = (KEY_W'(rd_key_q) & key_mask) == req_key_m;
  assign stamp_lt  = rd_stamp_q < best_stamp_q;
  assign last_slot = scan_q == IW'(SLOTS - 1);
  assign clock_inc = (clock_q == STAMP_MAX) ? clock_q : clock_q + STAMP_W'(1);

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    clock_d      = clock_q;
    key_bytes_d  = key_bytes_q;
    out_valid_d  = out_valid_q;
    scan_d       = scan_q;
    best_d       = best_q;
    target_d     = target_q;
    best_stamp_d = best_stamp_q;
    req_d        = req_q;
    res_d        = res_q;
    out_d        = out_q;
    stamp_we     = 1'b0;
    entry_we     = 1'b0;

    if (cfg_valid_i) begin
      key_bytes_d = cfg_data_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_i;
          scan_d  = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (req_q.op == OP_LOOKUP) begin
          if (valid_q[scan_q] && key_eq) begin
            target_d = scan_q;
            state_d  = S_WRITE;
          end else if (last_slot) begin
            res_d   = '0;
            state_d = S_FINISH;
          end else begin
            scan_d  = scan_q + IW'(1);
            state_d = S_READ;
          end
        end else begin
          if (!valid_q[scan_q]) begin
            target_d = scan_q;
            state_d  = S_WRITE;
          end else begin
            if (scan_q == '0 || stamp_lt) begin
              best_d       = scan_q;
              best_stamp_d = rd_stamp_q;
            end
            if (last_slot) begin
              target_d = (scan_q == '0 || stamp_lt) ? scan_q : best_q;
              state_d  = S_WRITE;
            end else begin
              scan_d  = scan_q + IW'(1);
              state_d = S_READ;
            end
          end
        end
      end
      S_WRITE: begin
        clock_d          = clock_inc;
        stamp_we         = 1'b1;
        res_d            = '0;
        res_d.slot_index = IDX_W'(target_q);
        if (req_q.op == OP_LOOKUP) begin
          res_d.hit               = 1'b1;
          res_d.plan_out_handle   = HANDLE_W'(rd_plan_q);
          res_d.spline_out_handle = HANDLE_W'(rd_spline_q);
          res_d.accel_out_handle  = HANDLE_W'(rd_accel_q);
        end else begin
          entry_we          = 1'b1;
          valid_d[target_q] = 1'b1;
        end
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      clock_q     <= '0;
      key_bytes_q <= KEY_BYTES_RESET;
      out_valid_q <= 1'b0;
      scan_q      <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      clock_q     <= clock_d;
      key_bytes_q <= key_bytes_d;
      out_valid_q <= out_valid_d;
      scan_q      <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q       <= best_d;
    target_q     <= target_d;
    best_stamp_q <= best_stamp_d;
    req_q        <= req_d;
    res_q        <= res_d;
    out_q        <= out_d;
  end

  // slot storage, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (stamp_we) begin
      stamp_mem[target_q] <= clock_inc;
    end
    if (entry_we) begin
      key_mem[target_q]    <= KEY_BITS'(req_key_m);
      plan_mem[target_q]   <= HANDLE_BITS'(req_q.plan_handle);
      spline_mem[target_q] <= HANDLE_BITS'(req_q.spline_handle);
      accel_mem[target_q]  <= HANDLE_BITS'(req_q.accel_handle);
    end
    rd_key_q    <= key_mem[scan_q];
    rd_stamp_q  <= stamp_mem[scan_q];
    rd_plan_q   <= plan_mem[scan_q];
    rd_spline_q <= spline_mem[scan_q];
    rd_accel_q  <= accel_mem[scan_q];
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

@@ rtl/klsc_checker.sv @@
// port-level checker for the slot cache and its bind
`include "keyed_lru_slot_cache_unit_assert.svh"

module klsc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input klsc_pkg::klsc_out_t out_o
);
  import klsc_pkg::*;

  // result stays offered until taken
  `KLSC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_o))

  // an accepted item keeps the block busy through its read and compare steps
  `KLSC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o ##1 !in_ready_o)

  // an item that did not hit carries no handles
  `KLSC_ASSERT_IMPL(a_no_hit_zero, out_valid_o && !out_o.hit,
                    out_o.plan_out_handle == '0 && out_o.spline_out_handle == '0 &&
                    out_o.accel_out_handle == '0)

  // a result appears only once the sequencer has finished its item
  `KLSC_ASSERT_NEXT(a_rise_after_busy, !out_valid_o && in_valid_i && in_ready_o,
                    !out_valid_o)

endmodule

bind keyed_lru_slot_cache_unit klsc_checker u_klsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);

@@ sim/keyed_lru_slot_cache_unit_test.sv @@
// self-checking testbench for the keyed lru slot cache unit
module keyed_lru_slot_cache_unit_test;
  import klsc_pkg::*;

  localparam int unsigned SLOT_COUNT   = DEF_SLOTS;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned POOL_SIZE    = 12;
  localparam int unsigned PHASE_ITEMS  = 75;
  localparam int unsigned PRINT_CAP    = 40;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  klsc_in_t        in_data   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  klsc_out_t       out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [KB_W-1:0] cfg_data  = '0;

  // predicted cache contents
  logic                line_valid  [SLOT_COUNT];
  logic [KEY_W-1:0]    line_key    [SLOT_COUNT];
  logic [STAMP_W-1:0]  line_stamp  [SLOT_COUNT];
  logic [HANDLE_W-1:0] line_plan   [SLOT_COUNT];
  logic [HANDLE_W-1:0] line_spline [SLOT_COUNT];
  logic [HANDLE_W-1:0] line_accel  [SLOT_COUNT];
  logic [STAMP_W-1:0]  lru_clock;
  logic [KB_W-1:0]     model_key_bytes;

  klsc_out_t        pending_results[$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  int unsigned error_count   = 0;
  int unsigned items_sent    = 0;
  int unsigned lookup_hits   = 0;
  int unsigned lookup_misses = 0;
  int unsigned inserts_done  = 0;
  int unsigned width_writes  = 0;
  int unsigned cycle_count   = 0;
  int unsigned burst_left    = 0;
  bit          tx_gaps       = 1'b0;
  int unsigned rx_stall_pct  = 0;
  int unsigned hold_req      = 0;
  int unsigned hold_ack      = 0;
  int unsigned hold_left     = 0;
  int unsigned stall_left    = 0;

  keyed_lru_slot_cache_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("keyed_lru_slot_cache_unit verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= PRINT_CAP) $display("ERROR cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic logic [KEY_W-1:0] compare_mask();
    int unsigned nbytes;
    nbytes = model_key_bytes;
    if (nbytes == 0) nbytes = 1;
    if (nbytes > DEF_KEY_BITS / 8) nbytes = DEF_KEY_BITS / 8;
    if (nbytes * 8 >= KEY_W) return '1;
    return (KEY_W'(1) << (nbytes * 8)) - KEY_W'(1);
  endfunction

  function automatic logic [STAMP_W-1:0] advance_clock();
    if (lru_clock != STAMP_MAX) lru_clock = lru_clock + 1'b1;
    return lru_clock;
  endfunction

  function automatic klsc_out_t cache_predict(klsc_in_t item);
    klsc_out_t        res;
    logic [KEY_W-1:0] km;
    logic [KEY_W-1:0] key;
    int unsigned      victim;
    logic             placed;
    res    = '0;
    km     = compare_mask();
    key    = item.search_key & km;
    placed = 1'b0;
    victim = 0;
    if (item.op == OP_LOOKUP) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (!placed && line_valid[i] && (line_key[i] & km) == key) begin
          placed                = 1'b1;
          line_stamp[i]         = advance_clock();
          res.hit               = 1'b1;
          res.slot_index        = IDX_W'(i);
          res.plan_out_handle   = line_plan[i];
          res.spline_out_handle = line_spline[i];
          res.accel_out_handle  = line_accel[i];
        end
      end
    end else begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (!placed && !line_valid[i]) begin
          victim = i;
          placed = 1'b1;
        end
      end
      if (!placed) begin
        for (int i = 1; i < SLOT_COUNT; i++)
          if (line_stamp[i] < line_stamp[victim]) victim = i;
      end
      line_key[victim]    = key;
      line_plan[victim]   = item.plan_handle;
      line_spline[victim] = item.spline_handle;
      line_accel[victim]  = item.accel_handle;
      line_stamp[victim]  = advance_clock();
      line_valid[victim]  = 1'b1;
      res.slot_index      = IDX_W'(victim);
    end
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  function automatic klsc_in_t make_item(logic op, logic [KEY_W-1:0] key,
                                         logic [HANDLE_W-1:0] plan,
                                         logic [HANDLE_W-1:0] spline,
                                         logic [HANDLE_W-1:0] accel);
    klsc_in_t item;
    item.op            = op;
    item.search_key    = key;
    item.plan_handle   = plan;
    item.spline_handle = spline;
    item.accel_handle  = accel;
    return item;
  endfunction

  // mostly keys from the pool so hits and evictions happen, some pure noise
  function automatic klsc_in_t random_item();
    klsc_in_t         item;
    logic [KEY_W-1:0] km;
    km                 = compare_mask();
    item.op            = ($urandom_range(0, 99) < 45) ? OP_INSERT : OP_LOOKUP;
    item.plan_handle   = $urandom();
    item.spline_handle = $urandom();
    item.accel_handle  = $urandom();
    if ($urandom_range(0, 99) < 85) begin
      item.search_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      if ($urandom_range(0, 4) == 0)
        item.search_key = (item.search_key & km) | (rand_key() & ~km);
    end else begin
      item.search_key = rand_key();
    end
    return item;
  endfunction

  task automatic fill_key_pool();
    for (int j = 0; j < POOL_SIZE; j++) begin
      key_pool[j] = rand_key();
      // neighbours sharing low bytes alias under narrow widths
      if (j > 0 && $urandom_range(0, 2) == 0)
        key_pool[j][15:0] = key_pool[j-1][15:0];
    end
  endtask

  task automatic send_item(klsc_in_t item);
    int unsigned gap;
    klsc_out_t   res;
    if (burst_left == 0) begin
      if (tx_gaps) begin
        gap = $urandom_range(0, 8);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    res = cache_predict(item);
    pending_results = {pending_results, res};
    items_sent++;
    if (item.op == OP_INSERT) inserts_done++;
    else if (res.hit) lookup_hits++;
    else lookup_misses++;
  endtask

  task automatic end_burst();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  task automatic set_key_bytes(logic [KB_W-1:0] value);
    end_burst();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_key_bytes = value;
    width_writes++;
  endtask

  // receiver: short random stalls, plus a long hold when asked
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    klsc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with no item pending: %h", out_data));
      end else begin
        want = pending_results.pop_front();
        if (out_data.hit !== want.hit)
          report_mismatch($sformatf("hit %b, want %b", out_data.hit, want.hit));
        if (out_data.slot_index !== want.slot_index)
          report_mismatch($sformatf("slot_index %0d, want %0d",
                                    out_data.slot_index, want.slot_index));
        if (out_data.plan_out_handle !== want.plan_out_handle)
          report_mismatch($sformatf("plan_out_handle %h, want %h",
                                    out_data.plan_out_handle, want.plan_out_handle));
        if (out_data.spline_out_handle !== want.spline_out_handle)
          report_mismatch($sformatf("spline_out_handle %h, want %h",
                                    out_data.spline_out_handle, want.spline_out_handle));
        if (out_data.accel_out_handle !== want.accel_out_handle)
          report_mismatch($sformatf("accel_out_handle %h, want %h",
                                    out_data.accel_out_handle, want.accel_out_handle));
      end
    end
  end

  // empty cache misses, fill, duplicate keys, eviction of the oldest slot
  task automatic test_fill_and_evict();
    tx_gaps      = 1'b1;
    rx_stall_pct = 30;
    send_item(make_item(OP_LOOKUP, '0, $urandom(), $urandom(), $urandom()));
    send_item(make_item(OP_LOOKUP, '1, $urandom(), $urandom(), $urandom()));
    send_item(make_item(OP_INSERT, '0, '0, '0, '0));
    send_item(make_item(OP_INSERT, '1, '1, '1, '1));
    send_item(make_item(OP_LOOKUP, '0, '1, '1, '1));
    send_item(make_item(OP_LOOKUP, '1, '0, '0, '0));
    send_item(make_item(OP_INSERT, '1, 32'h1234_5678, 32'h9abc_def0, 32'h0f0f_f0f0));
    send_item(make_item(OP_LOOKUP, '1, '0, '0, '0));
    for (int k = 0; k < 5; k++)
      send_item(make_item(OP_INSERT, 64'h0123_4567_89ab_cd00 + k,
                          $urandom(), $urandom(), $urandom()));
    send_item(make_item(OP_LOOKUP, '0, '0, '0, '0));
    send_item(make_item(OP_INSERT, 64'hdead_beef_cafe_f00d, $urandom(), $urandom(),
                        $urandom()));
    send_item(make_item(OP_LOOKUP, '1, '0, '0, '0));
    send_item(make_item(OP_LOOKUP, 64'h0123_4567_89ab_cd00, '0, '0, '0));
  endtask

  // narrow, zero and oversized widths, and keys stored under a narrower width
  task automatic test_key_widths();
    set_key_bytes(4'd1);
    send_item(make_item(OP_INSERT, 64'h1111_2222_3333_44ab, $urandom(), $urandom(),
                        $urandom()));
    send_item(make_item(OP_LOOKUP, 64'hffff_ffff_ffff_ffab, '0, '0, '0));
    set_key_bytes(4'd0);
    send_item(make_item(OP_LOOKUP, 64'h0000_0000_0000_00ab, '0, '0, '0));
    set_key_bytes(4'd15);
    send_item(make_item(OP_LOOKUP, 64'h1111_2222_3333_44ab, '0, '0, '0));
    send_item(make_item(OP_LOOKUP, 64'h0000_0000_0000_00ab, '0, '0, '0));
    set_key_bytes(KEY_BYTES_RESET);
    send_item(make_item(OP_LOOKUP, 64'h0000_0000_0000_00ab, '0, '0, '0));
  endtask

  task automatic test_random_widths();
    int unsigned widths[11] = '{8, 1, 0, 3, 15, 2, 5, 9, 4, 7, 6};
    for (int ph = 0; ph < 11; ph++) begin
      set_key_bytes(KB_W'(widths[ph]));
      fill_key_pool();
      tx_gaps      = (ph % 3 != 0);
      rx_stall_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 20 : 45);
      repeat (PHASE_ITEMS) send_item(random_item());
    end
  endtask

  // long receiver hold while the sender keeps offering items
  task automatic test_output_hold();
    end_burst();
    fill_key_pool();
    tx_gaps      = 1'b0;
    rx_stall_pct = 0;
    hold_req     = hold_req + 1;
    repeat (40) send_item(random_item());
  endtask

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      line_valid[i]  = 1'b0;
      line_key[i]    = '0;
      line_stamp[i]  = '0;
      line_plan[i]   = '0;
      line_spline[i] = '0;
      line_accel[i]  = '0;
    end
    lru_clock       = '0;
    model_key_bytes = KEY_BYTES_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fill_and_evict();
    test_key_widths();
    test_random_widths();
    test_output_hold();

    end_burst();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d items: %0d inserts, %0d lookup hits, %0d lookup misses",
             items_sent, inserts_done, lookup_hits, lookup_misses);
    $display("key width written %0d times, including zero and oversized values, with %0d errors",
             width_writes, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("keyed_lru_slot_cache_unit verification clean");
    end else begin
      $display("keyed_lru_slot_cache_unit verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/klsc_pkg.sv
rtl/keyed_lru_slot_cache_unit.sv
rtl/klsc_checker.sv
sim/keyed_lru_slot_cache_unit_test.sv
